// ===== design/lru_keyed_message_cache_assert.svh =====
// Assertion macros shared by the cache checker.
`ifndef LRU_KEYED_MESSAGE_CACHE_ASSERT_SVH
`define LRU_KEYED_MESSAGE_CACHE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LKMC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lkmc check failed");

// Next-cycle implication, disabled while reset is high.
`define LKMC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lkmc check failed");

`endif

// ===== design/lkmc_pkg.sv =====
// Shared widths, request codes and store write-enable type for the keyed cache.
package lkmc_pkg;

   localparam int unsigned DEFAULT_ENTRIES = 16;
   localparam int unsigned REQ_W  = 2;
   localparam int unsigned KEY_W  = 48;
   localparam int unsigned DATA_W = 64;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned CNT_W  = 64;
   localparam int unsigned CAP_W  = 5;
   localparam int unsigned OCC_W  = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [REQ_W-1:0] {
      REQ_INSERT = 2'd0,
      REQ_LOOKUP = 2'd1,
      REQ_TOUCH  = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_code_type;

   typedef struct packed {
      logic we_entry;   // key and payload
      logic we_time;    // access time
   } store_wen_type;

endpackage

// ===== design/lkmc_store.sv =====
// Entry store: key, payload and access-time arrays, one write and one registered read port.
module lkmc_store #(
   parameter int unsigned ENTRIES = lkmc_pkg::DEFAULT_ENTRIES,
   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                        clock,
   input  logic [IDX_W-1:0]            rd_addr,
   output logic [lkmc_pkg::KEY_W-1:0]  rd_key,
   output logic [lkmc_pkg::DATA_W-1:0] rd_payload,
   output logic [lkmc_pkg::TIME_W-1:0] rd_time,
   input  lkmc_pkg::store_wen_type     wen,
   input  logic [IDX_W-1:0]            wr_addr,
   input  logic [lkmc_pkg::KEY_W-1:0]  wr_key,
   input  logic [lkmc_pkg::DATA_W-1:0] wr_payload,
   input  logic [lkmc_pkg::TIME_W-1:0] wr_time
);
   import lkmc_pkg::*;

   logic [KEY_W-1:0]  key_mem     [ENTRIES];
   logic [DATA_W-1:0] payload_mem [ENTRIES];
   logic [TIME_W-1:0] time_mem    [ENTRIES];

   logic [KEY_W-1:0]  rd_key_ff;
   logic [DATA_W-1:0] rd_payload_ff;
   logic [TIME_W-1:0] rd_time_ff;

   always_ff @(posedge clock) begin
      if (wen.we_entry) begin
         key_mem[wr_addr]     <= wr_key;
         payload_mem[wr_addr] <= wr_payload;
      end
      if (wen.we_time) begin
         time_mem[wr_addr] <= wr_time;
      end
   end

   always_ff @(posedge clock) begin
      rd_key_ff     <= key_mem[rd_addr];
      rd_payload_ff <= payload_mem[rd_addr];
      rd_time_ff    <= time_mem[rd_addr];
   end

   assign rd_key     = rd_key_ff;
   assign rd_payload = rd_payload_ff;
   assign rd_time    = rd_time_ff;

endmodule

// ===== design/lkmc_scan.sv =====
// Shared compare unit: key match and oldest access time, one entry per cycle while cmp_vld is high.
module lkmc_scan #(
   parameter int unsigned ENTRIES = lkmc_pkg::DEFAULT_ENTRIES,
   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        scan_start,
   input  logic                        cmp_vld,
   input  logic [IDX_W-1:0]            cmp_idx,
   input  logic [lkmc_pkg::KEY_W-1:0]  key,
   input  logic [lkmc_pkg::KEY_W-1:0]  rd_key,
   input  logic [lkmc_pkg::DATA_W-1:0] rd_payload,
   input  logic [lkmc_pkg::TIME_W-1:0] rd_time,
   output logic                        found,
   output logic [IDX_W-1:0]            found_idx,
   output logic [lkmc_pkg::DATA_W-1:0] found_payload,
   output logic [IDX_W-1:0]            oldest_idx
);
   import lkmc_pkg::*;

   logic              found_ff, found_in;
   logic              have_ff, have_in;
   logic [IDX_W-1:0]  found_idx_ff, found_idx_in;
   logic [DATA_W-1:0] payload_ff, payload_in;
   logic [IDX_W-1:0]  oldest_idx_ff, oldest_idx_in;
   logic [TIME_W-1:0] oldest_time_ff, oldest_time_in;

   always_comb begin
      found_in       = found_ff;
      have_in        = have_ff;
      found_idx_in   = found_idx_ff;
      payload_in     = payload_ff;
      oldest_idx_in  = oldest_idx_ff;
      oldest_time_in = oldest_time_ff;
      if (scan_start) begin
         found_in      = 1'b0;
         have_in       = 1'b0;
         oldest_idx_in = '0;
      end else if (cmp_vld) begin
         // keep the lowest matching slot
         if (!found_ff && (rd_key == key)) begin
            found_in     = 1'b1;
            found_idx_in = cmp_idx;
            payload_in   = rd_payload;
         end
         // strict less-than keeps the lowest index on ties
         if (!have_ff || (rd_time < oldest_time_ff)) begin
            have_in        = 1'b1;
            oldest_idx_in  = cmp_idx;
            oldest_time_in = rd_time;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff      <= 1'b0;
         have_ff       <= 1'b0;
         oldest_idx_ff <= '0;
      end else begin
         found_ff      <= found_in;
         have_ff       <= have_in;
         oldest_idx_ff <= oldest_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      found_idx_ff   <= found_idx_in;
      payload_ff     <= payload_in;
      oldest_time_ff <= oldest_time_in;
   end

   assign found         = found_ff;
   assign found_idx     = found_idx_ff;
   assign found_payload = payload_ff;
   assign oldest_idx    = oldest_idx_ff;

endmodule

// ===== design/lru_keyed_message_cache.sv =====
// Top level of the fully associative keyed message cache with LRU replacement.
//
//   channel   ports                                    handshake
//   --------  ---------------------------------------  ----------------------------
//   request   req_type req_msg_key req_content_in      taken when start && !busy
//             req_now_time
//   response  rsp_success rsp_content_out              rsp_valid, one cycle, no stall
//             rsp_hit_count rsp_miss_count rsp_occupancy
//   csr       csr_capacity_in_use                      written when csr_wr_en
//
// A request walks the filled slots once through the store's single read port,
// one slot per cycle, and the response is registered from the commit state;
// a clear skips the walk and goes straight to commit.
// busy drops in the cycle the response is shown, so the next request may be
// taken there. Synchronous reset empties the cache, zeroes both counters and sets
// capacity to 16; no clearing pass is needed. The response side cannot stall.
module lru_keyed_message_cache #(
   parameter int unsigned ENTRIES = lkmc_pkg::DEFAULT_ENTRIES,
   localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   localparam int unsigned FILL_W = $clog2(ENTRIES + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   // request
   input  logic                        start,
   output logic                        busy,
   input  logic [lkmc_pkg::REQ_W-1:0]  req_type,
   input  logic [lkmc_pkg::KEY_W-1:0]  req_msg_key,
   input  logic [lkmc_pkg::DATA_W-1:0] req_content_in,
   input  logic [lkmc_pkg::TIME_W-1:0] req_now_time,
   // response
   output logic                        rsp_valid,
   output logic                        rsp_success,
   output logic [lkmc_pkg::DATA_W-1:0] rsp_content_out,
   output logic [lkmc_pkg::CNT_W-1:0]  rsp_hit_count,
   output logic [lkmc_pkg::CNT_W-1:0]  rsp_miss_count,
   output logic [lkmc_pkg::OCC_W-1:0]  rsp_occupancy,
   // configuration
   input  logic                        csr_wr_en,
   input  logic [lkmc_pkg::CAP_W-1:0]  csr_capacity_in_use
);
   import lkmc_pkg::*;

   localparam int unsigned EC_W = (FILL_W > CAP_W) ? FILL_W : CAP_W;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [FILL_W-1:0]  rd_idx_ff, rd_idx_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;

   // latched request
   req_code_type       op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [DATA_W-1:0]  content_ff;
   logic [TIME_W-1:0]  now_ff;

   // architectural state
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]   hit_ff, hit_in;
   logic [CNT_W-1:0]   miss_ff, miss_in;
   logic [CAP_W-1:0]   cap_ff;

   // response registers
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_success_ff, rsp_success_in;
   logic [DATA_W-1:0]  rsp_content_ff, rsp_content_in;

   logic               accept;
   logic [IDX_W-1:0]   rd_addr;
   logic [KEY_W-1:0]   rd_key;
   logic [DATA_W-1:0]  rd_payload;
   logic [TIME_W-1:0]  rd_time;
   logic               found;
   logic [IDX_W-1:0]   found_idx;
   logic [DATA_W-1:0]  found_payload;
   logic [IDX_W-1:0]   oldest_idx;
   store_wen_type      wen;
   logic [IDX_W-1:0]   wr_addr;
   logic [EC_W-1:0]    cap_ext;
   logic [EC_W-1:0]    eff_cap;
   logic               append;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign rd_addr = rd_idx_ff[IDX_W-1:0];

   // Sequencer: issue one slot read per cycle, wait for the last compare, commit.
   always_comb begin
      state_in   = state_ff;
      rd_idx_in  = rd_idx_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rd_idx_in = '0;
               state_in  = (req_code_type'(req_type) == REQ_CLEAR) ? ST_COMMIT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_idx_ff < fill_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_idx_ff[IDX_W-1:0];
               rd_idx_in  = rd_idx_ff + FILL_W'(1);
            end else if (!cmp_vld_ff) begin
               // last compare has landed in the scan unit
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Capacity zero acts as one; anything above the store size saturates.
   always_comb begin
      cap_ext = EC_W'(cap_ff);
      if (cap_ext == '0) begin
         eff_cap = EC_W'(1);
      end else if (cap_ext > EC_W'(ENTRIES)) begin
         eff_cap = EC_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
      append = (EC_W'(fill_ff) < eff_cap);
   end

   // Commit: update store, counters and fill, and load the response.
   always_comb begin
      wen            = '0;
      wr_addr        = found_idx;
      fill_in        = fill_ff;
      hit_in         = hit_ff;
      miss_in        = miss_ff;
      rsp_valid_in   = 1'b0;
      rsp_success_in = rsp_success_ff;
      rsp_content_in = rsp_content_ff;
      if (state_ff == ST_COMMIT) begin
         rsp_valid_in   = 1'b1;
         rsp_success_in = 1'b0;
         rsp_content_in = '0;
         case (op_ff)
            REQ_INSERT: begin
               if (!found) begin
                  rsp_success_in = 1'b1;
                  wen.we_entry   = 1'b1;
                  wen.we_time    = 1'b1;
                  if (append) begin
                     wr_addr = fill_ff[IDX_W-1:0];
                     fill_in = fill_ff + FILL_W'(1);
                  end else begin
                     // full: evict the least recently used slot
                     wr_addr = oldest_idx;
                  end
               end
            end
            REQ_LOOKUP: begin
               if (found) begin
                  rsp_success_in = 1'b1;
                  rsp_content_in = found_payload;
                  hit_in         = hit_ff + CNT_W'(1);
               end else begin
                  miss_in = miss_ff + CNT_W'(1);
               end
            end
            REQ_TOUCH: begin
               if (found) begin
                  rsp_success_in = 1'b1;
                  wen.we_time    = 1'b1;
               end
            end
            default: begin
               // clear: drop every slot and zero the counters
               fill_in = '0;
               hit_in  = '0;
               miss_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rd_idx_ff      <= '0;
         cmp_vld_ff     <= 1'b0;
         fill_ff        <= '0;
         hit_ff         <= '0;
         miss_ff        <= '0;
         cap_ff         <= CAP_RESET;
         rsp_valid_ff   <= 1'b0;
         rsp_success_ff <= 1'b0;
         rsp_content_ff <= '0;
      end else begin
         state_ff       <= state_in;
         rd_idx_ff      <= rd_idx_in;
         cmp_vld_ff     <= cmp_vld_in;
         fill_ff        <= fill_in;
         hit_ff         <= hit_in;
         miss_ff        <= miss_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_success_ff <= rsp_success_in;
         rsp_content_ff <= rsp_content_in;
         if (csr_wr_en) begin
            cap_ff <= csr_capacity_in_use;
         end
      end
   end

   // Hold the request fields for the whole walk.
   always_ff @(posedge clock) begin
      cmp_idx_ff <= cmp_idx_in;
      if (accept) begin
         op_ff      <= req_code_type'(req_type);
         key_ff     <= req_msg_key;
         content_ff <= req_content_in;
         now_ff     <= req_now_time;
      end
   end

   lkmc_store #(
      .ENTRIES (ENTRIES)
   ) u_store (
      .clock      (clock),
      .rd_addr    (rd_addr),
      .rd_key     (rd_key),
      .rd_payload (rd_payload),
      .rd_time    (rd_time),
      .wen        (wen),
      .wr_addr    (wr_addr),
      .wr_key     (key_ff),
      .wr_payload (content_ff),
      .wr_time    (now_ff)
   );

   lkmc_scan #(
      .ENTRIES (ENTRIES)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .scan_start    (accept),
      .cmp_vld       (cmp_vld_ff),
      .cmp_idx       (cmp_idx_ff),
      .key           (key_ff),
      .rd_key        (rd_key),
      .rd_payload    (rd_payload),
      .rd_time       (rd_time),
      .found         (found),
      .found_idx     (found_idx),
      .found_payload (found_payload),
      .oldest_idx    (oldest_idx)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_success     = rsp_success_ff;
   assign rsp_content_out = rsp_content_ff;
   assign rsp_hit_count   = hit_ff;
   assign rsp_miss_count  = miss_ff;
   assign rsp_occupancy   = OCC_W'(fill_ff);

endmodule

// ===== design/lkmc_checker.sv =====
// Port-level checker for the keyed message cache, bound to the top level.
`include "lru_keyed_message_cache_assert.svh"

module lkmc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic                        rsp_success,
   input logic [lkmc_pkg::DATA_W-1:0] rsp_content_out
);
   import lkmc_pkg::*;

   // a taken request holds the block busy in the next cycle
   `LKMC_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy)
   // no two response strobes in a row
   `LKMC_ASSERT_NXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   // the block is free again while the response is shown
   `LKMC_ASSERT_IMP(a_free_on_rsp, clock, reset, rsp_valid, !busy)
   // content is zero on every failed request
   `LKMC_ASSERT_IMP(a_zero_content, clock, reset, rsp_valid && !rsp_success, rsp_content_out == '0)

endmodule

bind lru_keyed_message_cache lkmc_checker u_lkmc_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_success     (rsp_success),
   .rsp_content_out (rsp_content_out)
);
